FILE: design/igcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igcp_pkg
// Shared constants, types and helpers for the fix record parser.
// ----------------------------------------------------------------------------
package igcp_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned TIME_W    = 19;
  localparam int unsigned LAT_DEG_W = 7;
  localparam int unsigned LON_DEG_W = 10;
  localparam int unsigned MIN_W     = 17;
  localparam int unsigned ALT_MAG_W = 17;
  localparam int unsigned LAT_W     = 24;
  localparam int unsigned LON_W     = 27;
  localparam int unsigned ALT_W     = 18;
  localparam int unsigned DIGIT_W   = 4;

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_B     = 8'h42;
  localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CHAR_W     = 8'h57;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // Record layout (character positions within a line)
  localparam logic [POS_W-1:0] POS_TAG       = 5'd0;
  localparam logic [POS_W-1:0] POS_TIME_LAST = 5'd6;
  localparam logic [POS_W-1:0] POS_LATD_LAST = 5'd8;
  localparam logic [POS_W-1:0] POS_LATM_LAST = 5'd13;
  localparam logic [POS_W-1:0] POS_LAT_HEMI  = 5'd14;
  localparam logic [POS_W-1:0] POS_LOND_LAST = 5'd17;
  localparam logic [POS_W-1:0] POS_LONM_LAST = 5'd22;
  localparam logic [POS_W-1:0] POS_LON_HEMI  = 5'd23;
  localparam logic [POS_W-1:0] POS_VALIDITY  = 5'd24;
  localparam logic [POS_W-1:0] POS_ALT_FIRST = 5'd25;
  localparam logic [POS_W-1:0] REC_LEN       = 5'd30;

  // 1/60000 degree units per degree
  localparam logic [15:0] DEG_UNITS = 16'd60000;

  // Raw fields gathered over one line, plus the emit strobe
  typedef struct packed {
    logic                 emit;
    logic [TIME_W-1:0]    time_sec;
    logic [LAT_DEG_W-1:0] lat_deg;
    logic [MIN_W-1:0]     lat_min;
    logic                 lat_south;
    logic [LON_DEG_W-1:0] lon_deg;
    logic [MIN_W-1:0]     lon_min;
    logic                 lon_west;
    logic [ALT_MAG_W-1:0] alt_mag;
    logic                 alt_neg;
  } igcp_fix_t;

  // Seconds carried by one time digit at a given position
  function automatic logic [TIME_W-1:0] time_weight(input logic [POS_W-1:0] pos);
    logic [TIME_W-1:0] w;
    begin
      case (pos)
        5'd1:    w = 19'd36000;
        5'd2:    w = 19'd3600;
        5'd3:    w = 19'd600;
        5'd4:    w = 19'd60;
        5'd5:    w = 19'd10;
        5'd6:    w = 19'd1;
        default: w = '0;
      endcase
      return w;
    end
  endfunction

endpackage

FILE: design/igcp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igcp_byte_if / igcp_fix_if
// Valid/ready channels for text bytes in and fix results out.
// ----------------------------------------------------------------------------
interface igcp_byte_if;
  import igcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface igcp_fix_if;
  import igcp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        time_of_day_seconds;
  logic signed [LAT_W-1:0]  latitude_units;
  logic signed [LON_W-1:0]  longitude_units;
  logic signed [ALT_W-1:0]  altitude_value;

  modport source (output valid, output time_of_day_seconds, output latitude_units,
                  output longitude_units, output altitude_value, input ready);
  modport sink   (input valid, input time_of_day_seconds, input latitude_units,
                  input longitude_units, input altitude_value, output ready);
endinterface

FILE: design/igcp_field_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igcp_field_scan
// Per-byte line scanner: tracks position, match flag and digit accumulators.
// ----------------------------------------------------------------------------
module igcp_field_scan
  import igcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] data_byte,
  output igcp_fix_t         fix
);

  logic [POS_W-1:0]     pos, pos_next;
  logic                 line_ok, line_ok_next;
  logic [TIME_W-1:0]    time_acc, time_acc_next;
  logic [LAT_DEG_W-1:0] lat_deg, lat_deg_next;
  logic [MIN_W-1:0]     lat_min, lat_min_next;
  logic                 lat_south, lat_south_next;
  logic [LON_DEG_W-1:0] lon_deg, lon_deg_next;
  logic [MIN_W-1:0]     lon_min, lon_min_next;
  logic                 lon_west, lon_west_next;
  logic [ALT_MAG_W-1:0] alt_mag, alt_mag_next;
  logic                 alt_neg, alt_neg_next;

  logic               is_lf;
  logic               is_digit;
  logic [DIGIT_W-1:0] digit;

  // character class
  assign is_lf    = (data_byte == CHAR_LF);
  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign digit    = is_digit ? DIGIT_W'(data_byte - CHAR_ZERO) : '0;

  // next-state for one beat
  always_comb begin
    pos_next       = pos;
    line_ok_next   = line_ok;
    time_acc_next  = time_acc;
    lat_deg_next   = lat_deg;
    lat_min_next   = lat_min;
    lat_south_next = lat_south;
    lon_deg_next   = lon_deg;
    lon_min_next   = lon_min;
    lon_west_next  = lon_west;
    alt_mag_next   = alt_mag;
    alt_neg_next   = alt_neg;

    if (is_lf) begin
      // line ends: back to start-of-line state
      pos_next       = '0;
      line_ok_next   = 1'b1;
      time_acc_next  = '0;
      lat_deg_next   = '0;
      lat_min_next   = '0;
      lat_south_next = 1'b0;
      lon_deg_next   = '0;
      lon_min_next   = '0;
      lon_west_next  = 1'b0;
      alt_mag_next   = '0;
      alt_neg_next   = 1'b0;
    end else if (pos < REC_LEN) begin
      pos_next = pos + POS_W'(1);
      if (line_ok) begin
        if (pos == POS_TAG) begin
          if (data_byte != CHAR_B) line_ok_next = 1'b0;
        end else if (pos <= POS_TIME_LAST) begin
          if (is_digit) time_acc_next = time_acc + TIME_W'(digit) * time_weight(pos);
          else line_ok_next = 1'b0;
        end else if (pos <= POS_LATD_LAST) begin
          if (is_digit) lat_deg_next = LAT_DEG_W'(lat_deg * 4'd10) + LAT_DEG_W'(digit);
          else line_ok_next = 1'b0;
        end else if (pos <= POS_LATM_LAST) begin
          if (is_digit) lat_min_next = MIN_W'(lat_min * 4'd10) + MIN_W'(digit);
          else line_ok_next = 1'b0;
        end else if (pos == POS_LAT_HEMI) begin
          lat_south_next = (data_byte == CHAR_S);
        end else if (pos <= POS_LOND_LAST) begin
          if (is_digit) lon_deg_next = LON_DEG_W'(lon_deg * 4'd10) + LON_DEG_W'(digit);
          else line_ok_next = 1'b0;
        end else if (pos <= POS_LONM_LAST) begin
          if (is_digit) lon_min_next = MIN_W'(lon_min * 4'd10) + MIN_W'(digit);
          else line_ok_next = 1'b0;
        end else if (pos == POS_LON_HEMI) begin
          lon_west_next = (data_byte == CHAR_W);
        end else if (pos == POS_VALIDITY) begin
          if (data_byte != CHAR_A) line_ok_next = 1'b0;
        end else begin
          // altitude: optional leading minus
          if (is_digit) alt_mag_next = ALT_MAG_W'(alt_mag * 4'd10) + ALT_MAG_W'(digit);
          else if (pos == POS_ALT_FIRST && data_byte == CHAR_MINUS) alt_neg_next = 1'b1;
          else line_ok_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      line_ok   <= 1'b1;
      time_acc  <= '0;
      lat_deg   <= '0;
      lat_min   <= '0;
      lat_south <= 1'b0;
      lon_deg   <= '0;
      lon_min   <= '0;
      lon_west  <= 1'b0;
      alt_mag   <= '0;
      alt_neg   <= 1'b0;
    end else if (take) begin
      pos       <= pos_next;
      line_ok   <= line_ok_next;
      time_acc  <= time_acc_next;
      lat_deg   <= lat_deg_next;
      lat_min   <= lat_min_next;
      lat_south <= lat_south_next;
      lon_deg   <= lon_deg_next;
      lon_min   <= lon_min_next;
      lon_west  <= lon_west_next;
      alt_mag   <= alt_mag_next;
      alt_neg   <= alt_neg_next;
    end
  end

  // complete record closed by this beat's line feed
  assign fix.emit      = take && is_lf && line_ok && (pos == REC_LEN);
  assign fix.time_sec  = time_acc;
  assign fix.lat_deg   = lat_deg;
  assign fix.lat_min   = lat_min;
  assign fix.lat_south = lat_south;
  assign fix.lon_deg   = lon_deg;
  assign fix.lon_min   = lon_min;
  assign fix.lon_west  = lon_west;
  assign fix.alt_mag   = alt_mag;
  assign fix.alt_neg   = alt_neg;

endmodule

FILE: design/igcp_result_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igcp_result_reg
// Converts raw fields to signed units and holds the result beat.
// ----------------------------------------------------------------------------
module igcp_result_reg
  import igcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  igcp_fix_t  fix,
  output logic       stalled,
  igcp_fix_if.source res
);

  logic                valid;
  logic [LAT_W-1:0]    lat_mag;
  logic [LON_W-1:0]    lon_mag;
  logic [LAT_W-1:0]    lat_val;
  logic [LON_W-1:0]    lon_val;
  logic [ALT_W-1:0]    alt_val;
  logic [TIME_W-1:0]   time_q;
  logic [LAT_W-1:0]    lat_q;
  logic [LON_W-1:0]    lon_q;
  logic [ALT_W-1:0]    alt_q;

  // degrees * 60000 + thousandths of minute, then hemisphere sign
  assign lat_mag = LAT_W'(fix.lat_deg) * LAT_W'(DEG_UNITS) + LAT_W'(fix.lat_min);
  assign lon_mag = LON_W'(fix.lon_deg) * LON_W'(DEG_UNITS) + LON_W'(fix.lon_min);
  assign lat_val = fix.lat_south ? (LAT_W'(0) - lat_mag) : lat_mag;
  assign lon_val = fix.lon_west ? (LON_W'(0) - lon_mag) : lon_mag;
  assign alt_val = fix.alt_neg ? (ALT_W'(0) - ALT_W'(fix.alt_mag)) : ALT_W'(fix.alt_mag);

  // output beat holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fix.emit) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fix.emit) begin
      time_q <= fix.time_sec;
      lat_q  <= lat_val;
      lon_q  <= lon_val;
      alt_q  <= alt_val;
    end
  end

  assign stalled                 = valid && !res.ready;
  assign res.valid               = valid;
  assign res.time_of_day_seconds = time_q;
  assign res.latitude_units      = $signed(lat_q);
  assign res.longitude_units     = $signed(lon_q);
  assign res.altitude_value      = $signed(alt_q);

endmodule

FILE: design/igc_fix_record_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igc_fix_record_parser_unit
// Output: a fix beat is offered in the cycle after its closing line feed beat.
// Throughput: one text byte per cycle; input stalls only in reset or while a fix waits.
// Reset: synchronous rst returns the scanner to start of line, drops results.
// ----------------------------------------------------------------------------
module igc_fix_record_parser_unit
  import igcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  igcp_byte_if.sink  text,
  igcp_fix_if.source fix
);

  igcp_fix_t raw;
  logic      stalled;
  logic      take;

  // byte accepted whenever the result slot is free or draining
  assign text.ready = !rst && !stalled;
  assign take       = text.valid && text.ready;

  igcp_field_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (text.data_byte),
    .fix       (raw)
  );

  igcp_result_reg u_res (
    .clk     (clk),
    .rst     (rst),
    .fix     (raw),
    .stalled (stalled),
    .res     (fix)
  );

endmodule

FILE: design/igcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igcp_checker
// Port-level checks on the parser's channels over time.
// ----------------------------------------------------------------------------
module igcp_checker
  import igcp_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    text_valid,
  input logic                    text_ready,
  input logic [BYTE_W-1:0]       text_data_byte,
  input logic                    fix_valid,
  input logic                    fix_ready,
  input logic signed [ALT_W-1:0] fix_altitude_value
);

  // a held fix beat stays offered
  a_fix_hold: assert property (@(posedge clk) disable iff (rst)
    fix_valid && !fix_ready |=> fix_valid)
    else $error("fix beat dropped while stalled");

  // a new fix only follows an accepted line feed
  a_fix_after_lf: assert property (@(posedge clk) disable iff (rst)
    $rose(fix_valid) |-> $past(text_valid && text_ready && text_data_byte == CHAR_LF))
    else $error("fix beat without line feed");

  // single result slot: a stalled fix blocks the text channel
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    fix_valid && !fix_ready |-> !text_ready)
    else $error("text accepted while fix stalled");

  // altitude never below the four-digit negative range
  a_alt_range: assert property (@(posedge clk) disable iff (rst)
    fix_valid |-> fix_altitude_value >= -18'sd9999)
    else $error("altitude out of range");

endmodule

bind igc_fix_record_parser_unit igcp_checker u_igcp_checker (
  .clk                (clk),
  .rst                (rst),
  .text_valid         (text.valid),
  .text_ready         (text.ready),
  .text_data_byte     (text.data_byte),
  .fix_valid          (fix.valid),
  .fix_ready          (fix.ready),
  .fix_altitude_value (fix.altitude_value)
);

FILE: bench/tb_igc_fix_record_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_igc_fix_record_parser_unit
// Feeds flight-log text one byte per beat into the fix record parser and
// checks every fix beat against an in-bench line scanner that tracks the
// fixed-position record layout. Directed lines cover field extremes, signs,
// hemisphere handling, short and trailing text and a bad byte in each field;
// random lines are mostly well-formed records, with broken records and noise.
// ----------------------------------------------------------------------------
module tb_igc_fix_record_parser_unit;
  import igcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_CHARS  = 400;
  localparam int unsigned RANDOM_FIXES  = 8;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [BYTE_W-1:0] CHAR_N  = 8'h4E;
  localparam logic [BYTE_W-1:0] CHAR_E  = 8'h45;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam string ZERO_RECORD = "B0000000000000N00000000EA00000";

  typedef struct packed {
    logic [TIME_W-1:0]       secs;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [ALT_W-1:0] alt;
  } fix_word_t;

  logic clk = 1'b0;
  logic rst;

  igcp_byte_if text_if ();
  igcp_fix_if  fix_if ();

  igc_fix_record_parser_unit u_dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_if),
    .fix  (fix_if)
  );

  always #10 clk = ~clk;

  // Line scanner state
  int unsigned          scan_pos;
  bit                   line_ok;
  logic [TIME_W-1:0]    secs_acc;
  logic [LAT_DEG_W-1:0] lat_deg_acc;
  logic [MIN_W-1:0]     lat_min_acc;
  bit                   lat_south;
  logic [LON_DEG_W-1:0] lon_deg_acc;
  logic [MIN_W-1:0]     lon_min_acc;
  bit                   lon_west;
  logic [ALT_MAG_W-1:0] alt_mag_acc;
  bit                   alt_neg;
  int unsigned          digit_secs [6] = '{36000, 3600, 600, 60, 10, 1};

  fix_word_t            pending_fixes [$];
  logic [BYTE_W-1:0]    line_buf [$];

  int unsigned chars_scanned   = 0;
  int unsigned fixes_predicted = 0;
  int unsigned fail_count      = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned stall_left      = 0;
  bit          gaps_on         = 1'b1;
  bit          stalls_on       = 1'b1;

  // Back to start of line
  task automatic clear_line();
    scan_pos    = 0;
    line_ok     = 1'b1;
    secs_acc    = '0;
    lat_deg_acc = '0;
    lat_min_acc = '0;
    lat_south   = 1'b0;
    lon_deg_acc = '0;
    lon_min_acc = '0;
    lon_west    = 1'b0;
    alt_mag_acc = '0;
    alt_neg     = 1'b0;
  endtask

  // Advance the scanner by one accepted byte; queue a fix at a matching line end
  task automatic track_text_byte(input logic [BYTE_W-1:0] c);
    bit          dig;
    int unsigned d;
    int unsigned p;
    int unsigned mag;
    fix_word_t   fw;
    dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d   = dig ? c - CHAR_ZERO : 0;
    p   = scan_pos;
    if (c == CHAR_LF) begin
      chars_scanned++;
      if (line_ok && p >= REC_LEN) begin
        fw.secs = secs_acc;
        mag     = lat_deg_acc * 60000 + lat_min_acc;
        fw.lat  = LAT_W'(lat_south ? 0 - mag : mag);
        mag     = lon_deg_acc * 60000 + lon_min_acc;
        fw.lon  = LON_W'(lon_west ? 0 - mag : mag);
        mag     = alt_mag_acc;
        fw.alt  = ALT_W'(alt_neg ? 0 - mag : mag);
        pending_fixes.push_back(fw);
        fixes_predicted++;
      end
      clear_line();
    end else if (p < REC_LEN) begin
      chars_scanned++;
      scan_pos = p + 1;
      if (line_ok) begin
        if (p == POS_TAG) begin
          line_ok = (c == CHAR_B);
        end else if (p <= POS_TIME_LAST) begin
          if (dig) secs_acc = TIME_W'(secs_acc + d * digit_secs[p-1]);
          else line_ok = 1'b0;
        end else if (p <= POS_LATD_LAST) begin
          if (dig) lat_deg_acc = LAT_DEG_W'(lat_deg_acc * 10 + d);
          else line_ok = 1'b0;
        end else if (p <= POS_LATM_LAST) begin
          if (dig) lat_min_acc = MIN_W'(lat_min_acc * 10 + d);
          else line_ok = 1'b0;
        end else if (p == POS_LAT_HEMI) begin
          lat_south = (c == CHAR_S);
        end else if (p <= POS_LOND_LAST) begin
          if (dig) lon_deg_acc = LON_DEG_W'(lon_deg_acc * 10 + d);
          else line_ok = 1'b0;
        end else if (p <= POS_LONM_LAST) begin
          if (dig) lon_min_acc = MIN_W'(lon_min_acc * 10 + d);
          else line_ok = 1'b0;
        end else if (p == POS_LON_HEMI) begin
          lon_west = (c == CHAR_W);
        end else if (p == POS_VALIDITY) begin
          line_ok = (c == CHAR_A);
        end else begin
          // altitude: a leading minus is allowed only in the first slot
          if (dig) alt_mag_acc = ALT_MAG_W'(alt_mag_acc * 10 + d);
          else if (p == POS_ALT_FIRST && c == CHAR_MINUS) alt_neg = 1'b1;
          else line_ok = 1'b0;
        end
      end
    end
  endtask

  // Offer one byte and hold it until the parser takes the beat
  task automatic send_char(input logic [BYTE_W-1:0] c);
    text_if.valid     <= 1'b1;
    text_if.data_byte <= c;
    do @(posedge clk); while (!text_if.ready);
    track_text_byte(c);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_line_buf();
    foreach (line_buf[i]) send_char(line_buf[i]);
    send_char(CHAR_LF);
  endtask

  task automatic load_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_text_line(input string s);
    load_text(s);
    send_line_buf();
  endtask

  // All-zero record with one byte replaced
  task automatic send_patched_zero(input int unsigned pos, input logic [BYTE_W-1:0] c);
    load_text(ZERO_RECORD);
    line_buf[pos] = c;
    send_line_buf();
  endtask

  // Sender goes quiet until every queued fix has come out
  task automatic drain_fixes();
    text_if.valid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] rand_digit();
    return CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_non_lf();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(0, 255)); while (c == CHAR_LF);
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_hemi(input logic [BYTE_W-1:0] neg_char,
                                                  input logic [BYTE_W-1:0] pos_char);
    case ($urandom_range(0, 3))
      0:       return neg_char;
      1:       return pos_char;
      2:       return neg_char;
      default: return rand_non_lf();
    endcase
  endfunction

  // Well-formed record with random content and optional trailing text
  task automatic make_record();
    line_buf.delete();
    line_buf.push_back(CHAR_B);
    repeat (13) line_buf.push_back(rand_digit());
    line_buf.push_back(pick_hemi(CHAR_S, CHAR_N));
    repeat (8) line_buf.push_back(rand_digit());
    line_buf.push_back(pick_hemi(CHAR_W, CHAR_E));
    line_buf.push_back(CHAR_A);
    line_buf.push_back(($urandom_range(0, 3) == 0) ? CHAR_MINUS : rand_digit());
    repeat (4) line_buf.push_back(rand_digit());
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1) == 0) line_buf.push_back(CHAR_CR);
      repeat ($urandom_range(0, 6)) line_buf.push_back(rand_non_lf());
    end
  endtask

  // Record with one byte replaced or cut short
  task automatic make_broken_record();
    int unsigned n;
    make_record();
    if ($urandom_range(0, 1) == 0) begin
      n = $urandom_range(0, 29);
      case ($urandom_range(0, 2))
        0:       line_buf[n] = CHAR_ZERO - 8'd1;
        1:       line_buf[n] = CHAR_NINE + 8'd1;
        default: line_buf[n] = rand_non_lf();
      endcase
    end else begin
      n = $urandom_range(0, 29);
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end
  endtask

  task automatic make_noise_line();
    line_buf.delete();
    repeat ($urandom_range(0, 40)) line_buf.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic test_field_extremes();
    send_text_line(ZERO_RECORD);
    send_text_line("B9999999999999S99999999WA99999");
    send_text_line("B1101355206343N00006198WA00587\r");
  endtask

  task automatic test_special_cases();
    // altitude sign, minus zero, negated zero angles
    send_text_line("B0000000000000N00000000EA-9999");
    send_text_line("B2359595959999S17959999WA-0000");
    send_text_line("B0000000000000S00000000WA00000");
    // any non line feed byte is a legal hemisphere
    load_text(ZERO_RECORD);
    line_buf[POS_LAT_HEMI] = 8'h00;
    line_buf[POS_LON_HEMI] = 8'hFF;
    send_line_buf();
    // short and empty lines, then trailing text after a full record
    send_text_line("B123456");
    send_text_line("");
    send_text_line("B1200004500000N00730000EA01234 trailing text, B and more\r");
    load_text("");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    send_line_buf();
  endtask

  task automatic test_malformed_lines();
    send_patched_zero(POS_TAG, "b");
    send_patched_zero(3, ":");
    send_patched_zero(7, "/");
    send_patched_zero(11, " ");
    send_patched_zero(16, CHAR_A);
    send_patched_zero(20, CHAR_MINUS);
    send_patched_zero(POS_VALIDITY, "V");
    send_patched_zero(POS_ALT_FIRST, "+");
    send_patched_zero(POS_ALT_FIRST + 1, CHAR_MINUS);
    send_patched_zero(REC_LEN - 1, " ");
    // scanner must recover on the next line
    send_text_line("B0102034512345N01234567EA00100");
  endtask

  task automatic test_random_lines();
    int unsigned chars_at_start;
    int unsigned fixes_at_start;
    int unsigned kind;
    chars_at_start = chars_scanned;
    fixes_at_start = fixes_predicted;
    while (chars_scanned - chars_at_start < RANDOM_CHARS ||
           fixes_predicted - fixes_at_start < RANDOM_FIXES) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 19);
      if (kind < 14) make_record();
      else if (kind < 17) make_broken_record();
      else make_noise_line();
      send_line_buf();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      make_record();
      send_line_buf();
    end
    drain_fixes();
    make_record();
    send_line_buf();
  endtask

  task automatic test_steady_tail();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (6) begin
      make_record();
      send_line_buf();
    end
  endtask

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    fail_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("[%0t] fix %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endtask

  // Compare one fix beat with the oldest queued fix
  task automatic check_fix_beat();
    fix_word_t fw;
    if (pending_fixes.size() == 0) begin
      mismatch_count++;
      fail_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("[%0t] fix beat with nothing queued: time %0d lat %0d lon %0d alt %0d",
                 $time, fix_if.time_of_day_seconds, fix_if.latitude_units,
                 fix_if.longitude_units, fix_if.altitude_value);
    end else begin
      fw = pending_fixes.pop_front();
      if (fix_if.time_of_day_seconds !== fw.secs)
        note_mismatch("time", fw.secs, fix_if.time_of_day_seconds);
      if (fix_if.latitude_units !== fw.lat)
        note_mismatch("latitude", fw.lat, fix_if.latitude_units);
      if (fix_if.longitude_units !== fw.lon)
        note_mismatch("longitude", fw.lon, fix_if.longitude_units);
      if (fix_if.altitude_value !== fw.alt)
        note_mismatch("altitude", fw.alt, fix_if.altitude_value);
    end
  endtask

  // Fix sink: check accepted beats, stall in random bursts
  always @(posedge clk) begin
    if (!rst && fix_if.valid && fix_if.ready) check_fix_beat();
    if (stall_left > 0) stall_left--;
    else if (stalls_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 15);
    fix_if.ready <= (stall_left == 0);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    text_if.valid     = 1'b0;
    text_if.data_byte = '0;
    clear_line();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_special_cases();
    test_malformed_lines();
    test_random_lines();
    test_drain_pause();
    test_steady_tail();

    drain_fixes();
    repeat (8) @(posedge clk);
    fail_count += pending_fixes.size();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
